// File: sv/afd_pkg.sv
// Shared types and constants for the addressed frame deframer.
// No dependencies; compiled before every other file.
`timescale 1ns / 1ps
package afd_pkg;

  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam logic [7:0]  LocalAddrRst = 8'h05;

  // register indexes (word offsets)
  localparam logic REG_LOCAL_ADDRESS = 1'b0;

  localparam logic [7:0] START_BYTE_A = 8'hAA;
  localparam logic [7:0] START_BYTE_B = 8'h55;
  localparam logic [7:0] END_BYTE_A   = 8'h55;
  localparam logic [7:0] END_BYTE_B   = 8'hAA;
  localparam logic [7:0] ER_FIRST     = 8'h45;  // 'E'
  localparam logic [7:0] ER_SECOND    = 8'h52;  // 'R'

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_START_B = 4'd1,
    PH_SOURCE  = 4'd2,
    PH_DEST    = 4'd3,
    PH_LENGTH  = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_CRC     = 4'd6,
    PH_END_A   = 4'd7,
    PH_END_B   = 4'd8
  } afd_phase_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [7:0]  payload_index;
    logic        frame_done;
    logic        frame_dropped;
    logic [7:0]  source_address;
    logic [7:0]  payload_length;
    logic [31:0] received_crc;
    logic        error_request;
  } afd_result_t;

endpackage

// File: sv/afd_channels.sv
// Handshake channel interfaces: received byte in, deframer result out.
// Depends on nothing; the top level uses both.
`timescale 1ns / 1ps
interface afd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afd_out_if;
  logic        valid;
  logic        ready;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [7:0]  payload_index;
  logic        frame_done;
  logic        frame_dropped;
  logic [7:0]  source_address;
  logic [7:0]  payload_length;
  logic [31:0] received_crc;
  logic        error_request;

  modport source (output valid, output data_valid, output data_byte,
                  output payload_index, output frame_done, output frame_dropped,
                  output source_address, output payload_length,
                  output received_crc, output error_request, input ready);
  modport sink   (input valid, input data_valid, input data_byte,
                  input payload_index, input frame_done, input frame_dropped,
                  input source_address, input payload_length,
                  input received_crc, input error_request, output ready);
endinterface

// File: sv/afd_parser.sv
// Frame parser: phase register, counters and held header fields, plus the
// per-beat result decode. Depends on afd_pkg.
`timescale 1ns / 1ps
module afd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         local_address,
  output afd_pkg::afd_result_t result
);
  import afd_pkg::*;

  afd_phase_t  phase_r, phase_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  source_r, source_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [1:0]  er_r, er_nxt;
  logic [7:0]  count_inc;

  assign count_inc = count_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      count_r  <= '0;
      length_r <= '0;
      source_r <= '0;
      crc_r    <= '0;
      er_r     <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      length_r <= length_nxt;
      source_r <= source_nxt;
      crc_r    <= crc_nxt;
      er_r     <= er_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    length_nxt = length_r;
    source_nxt = source_r;
    crc_nxt    = crc_r;
    er_nxt     = er_r;
    result     = '0;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == START_BYTE_A) phase_nxt = PH_START_B;
      end
      PH_START_B: begin
        if (rx_byte == START_BYTE_B) begin
          phase_nxt = PH_SOURCE;
        end else begin
          result.frame_dropped = 1'b1;
          phase_nxt = PH_HUNT;
        end
      end
      PH_SOURCE: begin
        source_nxt = rx_byte;
        phase_nxt  = PH_DEST;
      end
      PH_DEST: begin
        if (rx_byte == local_address) begin
          phase_nxt = PH_LENGTH;
        end else begin
          result.frame_dropped = 1'b1;
          phase_nxt = PH_HUNT;
        end
      end
      PH_LENGTH: begin
        length_nxt = rx_byte;
        count_nxt  = '0;
        er_nxt     = '0;
        crc_nxt    = '0;
        // empty payload goes straight to the CRC bytes
        phase_nxt  = (rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        result.data_valid    = 1'b1;
        result.data_byte     = rx_byte;
        result.payload_index = count_r;
        if (count_r == 8'd0 && rx_byte == ER_FIRST)  er_nxt[0] = 1'b1;
        if (count_r == 8'd1 && rx_byte == ER_SECOND) er_nxt[1] = 1'b1;
        // 8-bit wrap of the incremented count is intended
        if (count_inc >= length_r) begin
          count_nxt = '0;
          phase_nxt = PH_CRC;
        end else begin
          count_nxt = count_inc;
        end
      end
      PH_CRC: begin
        crc_nxt = {crc_r[23:0], rx_byte};
        if (count_r >= 8'd3) begin
          count_nxt = '0;
          phase_nxt = PH_END_A;
        end else begin
          count_nxt = count_inc;
        end
      end
      PH_END_A: begin
        if (rx_byte == END_BYTE_A) begin
          phase_nxt = PH_END_B;
        end else begin
          result.frame_dropped = 1'b1;
          phase_nxt = PH_HUNT;
        end
      end
      PH_END_B: begin
        if (rx_byte == END_BYTE_B) begin
          result.frame_done     = 1'b1;
          result.source_address = source_r;
          result.payload_length = length_r;
          result.received_crc   = crc_r;
          result.error_request  = &er_r;
        end else begin
          result.frame_dropped = 1'b1;
        end
        phase_nxt = PH_HUNT;
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

endmodule

// File: sv/addressed_frame_deframer_top.sv
// Channel      Dir   Width      Notes
// in_bus       in    8          rx_byte, one received byte per beat
// out_bus      out   1+8+8+...  one result beat per input beat
// psel/paddr.. in    32 data    local_address at byte offset 0
//
// One result per input byte, available the cycle after the byte is taken;
// sustained rate is one byte per clock while out_bus.ready stays high,
// through the phase register update. rst_n is synchronous: phase returns to
// hunting, local_address to 5. A held result blocks new input only while
// out_bus.ready is low; input and output are parted by the result register.
// Depends on afd_pkg, afd_channels and afd_parser.
`timescale 1ns / 1ps
module addressed_frame_deframer_top #(
  parameter logic [7:0] LOCAL_ADDR_RST = afd_pkg::LocalAddrRst
) (
  input  logic                          clk,
  input  logic                          rst_n,
  afd_in_if.sink                        in_bus,
  afd_out_if.source                     out_bus,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [afd_pkg::CfgAddrW-1:0]  paddr,
  input  logic [afd_pkg::CfgDataW-1:0]  pwdata,
  output logic [afd_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import afd_pkg::*;

  logic        addr_hit;
  logic [7:0]  local_address_r;
  logic        cfg_write;
  logic        in_fire;
  logic        out_valid_r;
  afd_result_t result;
  afd_result_t res_r;

  assign addr_hit  = (paddr[CfgAddrW-1:2] == REG_LOCAL_ADDRESS) &&
                     (paddr[1:0] == 2'b00);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= LOCAL_ADDR_RST;
    end else if (cfg_write && addr_hit) begin
      local_address_r <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (addr_hit) prdata = {{(CfgDataW-8){1'b0}}, local_address_r};
  end

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_fire      = in_bus.valid && in_bus.ready;

  afd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (in_fire),
    .rx_byte       (in_bus.rx_byte),
    .local_address (local_address_r),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      out_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) res_r <= result;
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.data_valid     = res_r.data_valid;
  assign out_bus.data_byte      = res_r.data_byte;
  assign out_bus.payload_index  = res_r.payload_index;
  assign out_bus.frame_done     = res_r.frame_done;
  assign out_bus.frame_dropped  = res_r.frame_dropped;
  assign out_bus.source_address = res_r.source_address;
  assign out_bus.payload_length = res_r.payload_length;
  assign out_bus.received_crc   = res_r.received_crc;
  assign out_bus.error_request  = res_r.error_request;

  a_fire_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted byte produced no result beat");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |-> !in_bus.ready)
    else $error("input taken while result beat is stalled");

  a_done_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.frame_done && res_r.frame_dropped))
    else $error("frame both done and dropped");

  a_data_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.data_valid && (res_r.frame_done || res_r.frame_dropped)))
    else $error("payload beat flagged as frame end");

  a_er_needs_len2: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.error_request) |-> (res_r.payload_length >= 8'd2))
    else $error("error request on frame shorter than two bytes");

endmodule
